/* rtl/hbm_pkg.sv */
// ----------------------------------------------------------------------------
// hbm_pkg
// shared types, codes and defaults for the head-to-body box matcher
// ----------------------------------------------------------------------------
`default_nettype none

package hbm_pkg;

  // default sizes
  localparam int MAX_HEADS_DEF  = 32;
  localparam int MAX_BODIES_DEF = 64;
  localparam int COORD_BITS_DEF = 12;

  // result field widths, fixed
  localparam int MATCHED_W = 1;
  localparam int BODY_NUM_W = 6;
  localparam int HEAD_NUM_W = 5;
  localparam int RES_W = MATCHED_W + BODY_NUM_W + HEAD_NUM_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MATCH = 2'd2
  } op_t;

  // flags that travel with a body word down the chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

  // store commands broadcast to every cell
  typedef struct packed {
    logic clr;
    logic wr_en;
    logic mark_en;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/hbm_cell.sv */
// ----------------------------------------------------------------------------
// hbm_cell
// one head slot: holds a head box and its used mark, scores the passing body
// ----------------------------------------------------------------------------
`default_nettype none

module hbm_cell
  import hbm_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IDX_W      = 5,
  parameter int HCNT_W     = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_cmd_t             cmd,
  input  wire logic [IDX_W-1:0]      cmd_idx,
  input  wire logic [COORD_BITS-1:0] wr_x,
  input  wire logic [COORD_BITS-1:0] wr_y,
  input  wire logic [COORD_BITS-1:0] wr_w,
  input  wire logic [COORD_BITS-1:0] wr_h,
  input  wire logic [HCNT_W-1:0]     head_count,
  input  wire tok_flags_t            in_flags,
  input  wire logic [IDX_W-1:0]      in_best,
  input  wire logic [COORD_BITS-1:0] in_dist,
  input  wire logic [COORD_BITS-1:0] in_bx,
  input  wire logic [COORD_BITS-1:0] in_by,
  input  wire logic [COORD_BITS-1:0] in_bw,
  input  wire logic [COORD_BITS-1:0] in_bh,
  output tok_flags_t                 out_flags,
  output logic      [IDX_W-1:0]      out_best,
  output logic      [COORD_BITS-1:0] out_dist,
  output logic      [COORD_BITS-1:0] out_bx,
  output logic      [COORD_BITS-1:0] out_by,
  output logic      [COORD_BITS-1:0] out_bw,
  output logic      [COORD_BITS-1:0] out_bh
);

  localparam int C = COORD_BITS;

  logic [C-1:0] hx, hy, hw, hh;
  logic         used;
  logic         hit;
  logic         live;
  logic         in_body;
  logic         take;
  logic [C+1:0] cx2, cy2, bl2, bt2;
  logic [C:0]   br_sum, bb_sum;
  logic [C+1:0] br2, bb2;
  logic [C-1:0] dy;

  assign hit = (cmd_idx == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (cmd.clr) begin
      used <= 1'b0;
    end else if (cmd.wr_en && hit) begin
      used <= 1'b0;
    end else if (cmd.mark_en && hit) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && hit) begin
      hx <= wr_x;
      hy <= wr_y;
      hw <= wr_w;
      hh <= wr_h;
    end
  end

  // doubled coordinates keep the half-pixel centre exact
  always_comb begin
    cx2     = {1'b0, hx, 1'b0} + {2'b00, hw};
    cy2     = {1'b0, hy, 1'b0} + {2'b00, hh};
    bl2     = {1'b0, in_bx, 1'b0};
    bt2     = {1'b0, in_by, 1'b0};
    br_sum  = {1'b0, in_bx} + {1'b0, in_bw};
    bb_sum  = {1'b0, in_by} + {1'b0, in_bh};
    br2     = {br_sum, 1'b0};
    bb2     = {bb_sum, 1'b0};
    in_body = (cx2 > bl2) && (cx2 < br2) && (cy2 > bt2) && (cy2 <= bb2);
    dy      = (hy > in_by) ? (hy - in_by) : (in_by - hy);
    live    = (HCNT_W'(INDEX) < head_count) && !used;
    take    = in_flags.valid && live && in_body && (!in_flags.found || dy < in_dist);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags.valid <= in_flags.valid;
      out_flags.found <= in_flags.found || take;
    end
  end

  always_ff @(posedge clk) begin
    out_best <= take ? IDX_W'(INDEX) : in_best;
    out_dist <= take ? dy : in_dist;
    out_bx   <= in_bx;
    out_by   <= in_by;
    out_bw   <= in_bw;
    out_bh   <= in_bh;
  end

endmodule

`default_nettype wire

/* rtl/head_to_body_box_matcher.sv */
// ----------------------------------------------------------------------------
// head_to_body_box_matcher
// greedy per-frame assignment of stored head boxes to incoming body boxes
// ----------------------------------------------------------------------------
// a match body word passes the entry stage and then each cell in turn; its result is
// registered into the output stage, or into the skid word while the output is stalled
// no new word is taken until that result has left the chain and no skid word waits
// start frame and load head words are likewise taken only when no body is in the chain
// reset clears used marks, head and body counts, the chain and the output stage
// head boxes are undefined after reset; only loaded slots are ever scored
// ----------------------------------------------------------------------------
`default_nettype none

module head_to_body_box_matcher
  import hbm_pkg::*;
#(
  parameter int MAX_HEADS  = MAX_HEADS_DEF,
  parameter int MAX_BODIES = MAX_BODIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,   // box_x, box_y, box_w, box_h, zero pad
  input  wire logic [OP_W-1:0] s_tuser,   // opcode
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [OUT_W-1:0]     m_tdata    // matched, body_number, head_number, zero pad
);

  localparam int C      = COORD_BITS;
  localparam int IDX_W  = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int HCNT_W = $clog2(MAX_HEADS + 1);
  localparam int BCNT_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  // input unpacking
  op_t          op;
  logic [C-1:0] in_x, in_y, in_w, in_h;
  logic         acc;

  assign op   = op_t'(s_tuser);
  assign in_x = s_tdata[C-1:0];
  assign in_y = s_tdata[2*C-1:C];
  assign in_w = s_tdata[3*C-1:2*C];
  assign in_h = s_tdata[4*C-1:3*C];
  assign acc  = s_tvalid && s_tready;

  // control state
  logic              busy;        // a body word is walking the chain
  logic [HCNT_W-1:0] head_count;
  logic [BCNT_W-1:0] body_count;
  logic [BCNT_W-1:0] body_num;    // number of the body now in the chain

  // skid word behind the output register
  logic              pend_valid;
  logic [RES_W-1:0]  pend_res;
  logic [RES_W-1:0]  out_res;

  // decoded word kinds
  logic is_start, is_load, is_match;

  always_comb begin
    is_start = 1'b0;
    is_load  = 1'b0;
    is_match = 1'b0;
    unique case (op)
      OP_START: is_start = 1'b1;
      OP_LOAD:  is_load  = 1'b1;
      OP_MATCH: is_match = 1'b1;
      default:  ;  // unused code, word is dropped
    endcase
  end

  // chain taps: stage 0 is loaded here, stage i+1 is cell i's register
  tok_flags_t        ch_flags [MAX_HEADS+1];
  logic [IDX_W-1:0]  ch_best  [MAX_HEADS+1];
  logic [C-1:0]      ch_dist  [MAX_HEADS+1];
  logic [C-1:0]      ch_bx    [MAX_HEADS+1];
  logic [C-1:0]      ch_by    [MAX_HEADS+1];
  logic [C-1:0]      ch_bw    [MAX_HEADS+1];
  logic [C-1:0]      ch_bh    [MAX_HEADS+1];
  logic [MAX_HEADS:0] ch_valid;

  // end of chain
  logic              exit_valid;
  logic              exit_found;
  logic [IDX_W-1:0]  exit_best;
  logic [RES_W-1:0]  exit_res;

  assign exit_valid = ch_flags[MAX_HEADS].valid;
  assign exit_found = ch_flags[MAX_HEADS].found;
  assign exit_best  = ch_best[MAX_HEADS];

  // result packing, matched in the lowest bit
  assign exit_res = {exit_found ? HEAD_NUM_W'(exit_best) : HEAD_NUM_W'(0),
                     BODY_NUM_W'(body_num),
                     exit_found};

  // the chain holds one body at a time; a waiting skid word also blocks input
  assign s_tready = !busy && !pend_valid;

  // commands to the cells
  cell_cmd_t        cmd;
  logic [IDX_W-1:0] cmd_idx;
  logic             store_full;

  assign store_full  = (head_count == HCNT_W'(MAX_HEADS));
  assign cmd.clr     = acc && is_start;
  assign cmd.wr_en   = acc && is_load && !store_full;
  assign cmd.mark_en = exit_valid && exit_found;
  // a mark and a load never meet: loads wait until the chain is empty
  assign cmd_idx     = cmd.mark_en ? exit_best : head_count[IDX_W-1:0];

  // counts and chain occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      head_count <= '0;
      body_count <= '0;
    end else begin
      if (acc && is_match) begin
        busy <= 1'b1;
      end else if (exit_valid) begin
        busy <= 1'b0;
      end
      if (cmd.clr) begin
        head_count <= '0;
        body_count <= '0;
      end else begin
        if (cmd.wr_en) begin
          head_count <= head_count + HCNT_W'(1);
        end
        // body count stops at the last number
        if (acc && is_match && body_count != BCNT_W'(MAX_BODIES - 1)) begin
          body_count <= body_count + BCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_match) begin
      body_num <= body_count;
    end
  end

  // chain entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_flags[0] <= '0;
    end else begin
      ch_flags[0].valid <= acc && is_match;
      ch_flags[0].found <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ch_best[0] <= '0;
    ch_dist[0] <= '0;
    ch_bx[0]   <= in_x;
    ch_by[0]   <= in_y;
    ch_bw[0]   <= in_w;
    ch_bh[0]   <= in_h;
  end

  // the row of head cells; earlier cells win ties
  for (genvar i = 0; i < MAX_HEADS; i++) begin : g_cell
    hbm_cell #(
      .INDEX      (i),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .HCNT_W     (HCNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cmd_idx    (cmd_idx),
      .wr_x       (in_x),
      .wr_y       (in_y),
      .wr_w       (in_w),
      .wr_h       (in_h),
      .head_count (head_count),
      .in_flags   (ch_flags[i]),
      .in_best    (ch_best[i]),
      .in_dist    (ch_dist[i]),
      .in_bx      (ch_bx[i]),
      .in_by      (ch_by[i]),
      .in_bw      (ch_bw[i]),
      .in_bh      (ch_bh[i]),
      .out_flags  (ch_flags[i+1]),
      .out_best   (ch_best[i+1]),
      .out_dist   (ch_dist[i+1]),
      .out_bx     (ch_bx[i+1]),
      .out_by     (ch_by[i+1]),
      .out_bw     (ch_bw[i+1]),
      .out_bh     (ch_bh[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_HEADS; i++) begin : g_vld
    assign ch_valid[i] = ch_flags[i].valid;
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && m_tready) begin
        pend_valid <= 1'b0;
        m_tvalid   <= 1'b1;
      end else if (exit_valid) begin
        if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && m_tready) begin
      out_res <= pend_res;
    end else if (exit_valid && (!m_tvalid || m_tready)) begin
      out_res <= exit_res;
    end
    if (exit_valid && m_tvalid && !m_tready) begin
      pend_res <= exit_res;
    end
  end

  assign m_tdata = OUT_W'(out_res);

  // checks
  a_one_body: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ch_valid))
    else $error("more than one body word in the cell chain");

  a_exit_busy: assert property (@(posedge clk) disable iff (rst)
    exit_valid |-> busy)
    else $error("chain produced a result with no body in flight");

  a_skid_full: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> m_tvalid)
    else $error("skid word held while output register is empty");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[RES_W-1:MATCHED_W+BODY_NUM_W] == '0))
    else $error("head number nonzero on an unmatched body");

  a_mark_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_en |-> !cmd.wr_en && !cmd.clr)
    else $error("used mark collides with a store write");

endmodule

`default_nettype wire

/* tb/head_to_body_box_matcher_tb.sv */
// ----------------------------------------------------------------------------
// head_to_body_box_matcher_tb
// self-checking bench: frames of head loads and body matches are streamed in,
// every body result is checked against a cycle-free model of the greedy match
// ----------------------------------------------------------------------------
`default_nettype none

module head_to_body_box_matcher_tb;
  import hbm_pkg::*;

  localparam int NUM_HEADS      = MAX_HEADS_DEF;
  localparam int NUM_BODIES     = MAX_BODIES_DEF;
  localparam int CB             = COORD_BITS_DEF;
  localparam int IN_W           = ((4 * CB + 7) / 8) * 8;
  localparam int COORD_MAX      = (1 << CB) - 1;
  localparam int WATCHDOG_LIMIT = 3000;

  // opcode with no meaning, the block must drop it
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [CB-1:0] h;
    logic [CB-1:0] w;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
  } box_t;

  typedef struct packed {
    logic                  matched;
    logic [BODY_NUM_W-1:0] body_num;
    logic [HEAD_NUM_W-1:0] head_num;
  } match_res_t;

  logic            clk      = 1'b0;
  logic            rst      = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata  = '0;   // box_x, box_y, box_w, box_h, zero pad
  logic [OP_W-1:0] s_tuser  = '0;   // opcode
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // matched, body_number, head_number, zero pad

  head_to_body_box_matcher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // model of the matcher: its own head store, used marks and counters
  // ---------------------------------------------------------------------------
  box_t       head_store [NUM_HEADS];
  bit         head_used  [NUM_HEADS];
  int         head_cnt = 0;
  int         body_cnt = 0;
  match_res_t expected_matches [$];

  // bookkeeping for the summary and the verdict
  int errors        = 0;
  int words_sent    = 0;
  int bodies_seen   = 0;
  int bodies_paired = 0;

  // idling knobs, percent per cycle
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // doubled head centre strictly inside horizontally, strictly below the top,
  // at or above the bottom of the body
  function automatic bit head_fits(box_t hd, box_t bd);
    int unsigned cx2, cy2;
    cx2 = 2 * int'(hd.x) + int'(hd.w);
    cy2 = 2 * int'(hd.y) + int'(hd.h);
    return cx2 > 2 * int'(bd.x) && cx2 < 2 * (int'(bd.x) + int'(bd.w)) &&
           cy2 > 2 * int'(bd.y) && cy2 <= 2 * (int'(bd.y) + int'(bd.h));
  endfunction

  function automatic void predict_word(logic [OP_W-1:0] op, box_t b);
    int unsigned dy, best_dist, best;
    bit          found;
    match_res_t  r;
    if (op == OP_START) begin
      foreach (head_used[i]) head_used[i] = 1'b0;
      head_cnt = 0;
      body_cnt = 0;
    end else if (op == OP_LOAD) begin
      // a full store drops the head silently
      if (head_cnt < NUM_HEADS) begin
        head_store[head_cnt] = b;
        head_used[head_cnt]  = 1'b0;
        head_cnt++;
      end
    end else if (op == OP_MATCH) begin
      found     = 1'b0;
      best      = 0;
      best_dist = 0;
      for (int i = 0; i < head_cnt; i++) begin
        if (!head_used[i] && head_fits(head_store[i], b)) begin
          dy = (head_store[i].y > b.y) ? int'(head_store[i].y) - int'(b.y)
                                       : int'(b.y) - int'(head_store[i].y);
          // strict less keeps the lowest index on a tie
          if (!found || dy < best_dist) begin
            found     = 1'b1;
            best      = i;
            best_dist = dy;
          end
        end
      end
      if (found) head_used[best] = 1'b1;
      r.matched  = found;
      r.body_num = BODY_NUM_W'(body_cnt);
      r.head_num = found ? HEAD_NUM_W'(best) : '0;
      expected_matches = {expected_matches, r};
      // body order saturates at the last slot
      if (body_cnt < NUM_BODIES - 1) body_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // box generators
  // ---------------------------------------------------------------------------
  function automatic box_t rand_box();
    box_t b;
    b.x = CB'($urandom_range(0, COORD_MAX));
    b.y = CB'($urandom_range(0, COORD_MAX));
    b.w = CB'($urandom_range(0, COORD_MAX));
    b.h = CB'($urandom_range(0, COORD_MAX));
    return b;
  endfunction

  // body of moderate size, mostly clear of the coordinate limit
  function automatic box_t rand_body();
    box_t b;
    b.x = CB'($urandom_range(0, 3500));
    b.y = CB'($urandom_range(0, 3500));
    b.w = CB'($urandom_range(1, 595));
    b.h = CB'($urandom_range(1, 595));
    return b;
  endfunction

  // small head whose doubled centre lands inside the given body
  function automatic box_t head_within(box_t bd);
    int unsigned cx2, cy2, hw, hh, hx, hy;
    box_t        hd;
    if (bd.w == 0 || bd.h == 0) return rand_box();
    cx2 = $urandom_range(2 * int'(bd.x) + 1, 2 * (int'(bd.x) + int'(bd.w)) - 1);
    cy2 = $urandom_range(2 * int'(bd.y) + 1, 2 * (int'(bd.y) + int'(bd.h)));
    hw  = $urandom_range(0, (cx2 < 63) ? cx2 : 63);
    hh  = $urandom_range(0, (cy2 < 63) ? cy2 : 63);
    // fix parity so that 2x + w hits the centre exactly
    if ((cx2 - hw) % 2) hw = (hw > 0) ? hw - 1 : hw + 1;
    if ((cy2 - hh) % 2) hh = (hh > 0) ? hh - 1 : hh + 1;
    hx = (cx2 - hw) / 2;
    hy = (cy2 - hh) / 2;
    if (hx > COORD_MAX || hy > COORD_MAX) return rand_box();
    hd.x = CB'(hx);
    hd.y = CB'(hy);
    hd.w = CB'(hw);
    hd.h = CB'(hh);
    return hd;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one word per call, model updated at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [OP_W-1:0] op, input box_t b);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_W'({b.h, b.w, b.y, b.x});
    do @(posedge clk); while (!s_tready);
    predict_word(op, b);
    if (op != OP_IGNORED) words_sent++;
    // random gap, never lowered and raised in the same step
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [OP_W-1:0] op, input int x, input int y,
                             input int w, input int h);
    box_t b;
    b.x = CB'(x);
    b.y = CB'(y);
    b.w = CB'(w);
    b.h = CB'(h);
    send_word(op, b);
  endtask

  // odd word now and then: any opcode, any content
  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) send_word(OP_W'($urandom_range(0, 3)), rand_box());
  endtask

  // ---------------------------------------------------------------------------
  // receiver stalls and result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    match_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.matched  = m_tdata[0];
      got.body_num = m_tdata[BODY_NUM_W:1];
      got.head_num = m_tdata[BODY_NUM_W+HEAD_NUM_W:BODY_NUM_W+1];
      bodies_seen++;
      if (got.matched) bodies_paired++;
      if (expected_matches.size() == 0) begin
        errors++;
        $display("%0t: body result with none pending: matched=%0d body=%0d head=%0d",
                 $time, got.matched, got.body_num, got.head_num);
      end else begin
        want = expected_matches.pop_front();
        if (got.matched !== want.matched || got.body_num !== want.body_num ||
            got.head_num !== want.head_num) begin
          errors++;
          $display("%0t: mismatch exp m=%0d b=%0d h=%0d got m=%0d b=%0d h=%0d",
                   $time, want.matched, want.body_num, want.head_num,
                   got.matched, got.body_num, got.head_num);
        end
      end
    end
  end

  // watchdog: too long with neither side moving a word
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked cases: no heads, ties, closer distance, edge conditions,
  // extreme coordinates and the ignored opcode
  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // body straight after reset, store empty
    send_fields(OP_MATCH, 10, 10, 100, 100);
    send_fields(OP_START, 0, 0, 0, 0);
    // two identical heads: tie goes to index 0, then 1, then none left
    send_fields(OP_LOAD, 100, 100, 20, 20);
    send_fields(OP_LOAD, 100, 100, 20, 20);
    send_fields(OP_MATCH, 90, 95, 40, 60);
    send_fields(OP_MATCH, 90, 95, 40, 60);
    send_fields(OP_MATCH, 90, 95, 40, 60);
    // edge conditions with point heads
    send_fields(OP_START, 0, 0, 0, 0);
    send_fields(OP_LOAD, 0, 0, 0, 0);        // centre on the left edge of any body at 0
    send_fields(OP_LOAD, 10, 10, 0, 0);
    send_fields(OP_LOAD, 10, 10, 0, 0);
    send_fields(OP_MATCH, 0, 0, 10, 10);     // centre on the right edge: no match
    send_fields(OP_MATCH, 0, 0, 11, 10);     // centre on the bottom edge: match
    send_fields(OP_MATCH, 0, 10, 11, 5);     // centre on the top edge: no match
    // all-ones coordinates, sums past the field width
    send_fields(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_fields(OP_MATCH, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    // ignored opcode must not disturb the frame
    send_fields(OP_IGNORED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    // nearer head in y wins over a lower index
    send_fields(OP_START, 0, 0, 0, 0);
    send_fields(OP_LOAD, 50, 50, 10, 10);
    send_fields(OP_LOAD, 50, 45, 10, 20);
    send_fields(OP_MATCH, 40, 40, 40, 40);
    send_fields(OP_MATCH, 40, 40, 40, 40);
  endtask

  // more heads than the store holds and more bodies than the body counter
  task automatic test_head_store_full();
    box_t whole;
    whole.x = '0;
    whole.y = '0;
    whole.w = CB'(COORD_MAX);
    whole.h = CB'(COORD_MAX);
    sender_idle_pct = 19;
    recv_stall_pct  = 84;
    send_word(OP_START, rand_box());
    for (int i = 0; i < NUM_HEADS + 4; i++) send_word(OP_LOAD, head_within(whole));
    for (int i = 0; i < NUM_BODIES + 3; i++)
      send_word(OP_MATCH, ($urandom_range(0, 3) == 0) ? rand_box() : whole);
  endtask

  // frames of random heads and bodies, most heads placed inside some body
  task automatic test_random_frames(input int n_words, input int idle_pct,
                                    input int stall_pct);
    box_t bodies [8];
    int   nb, nh, target;
    target          = words_sent + n_words;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    while (words_sent < target) begin
      // now and then a frame carries on from the last one
      if ($urandom_range(0, 9) != 0) send_word(OP_START, rand_box());
      nb = $urandom_range(1, 8);
      nh = $urandom_range(0, 10);
      for (int i = 0; i < nb; i++)
        bodies[i] = ($urandom_range(0, 7) == 0) ? rand_box() : rand_body();
      for (int i = 0; i < nh; i++) begin
        maybe_noise();
        send_word(OP_LOAD, ($urandom_range(0, 4) == 0) ? rand_box() :
                           head_within(bodies[$urandom_range(0, nb - 1)]));
      end
      for (int i = 0; i < nb; i++) begin
        maybe_noise();
        send_word(OP_MATCH, bodies[i]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_head_store_full();
    test_random_frames(125, 0, 0);
    test_random_frames(125, 84, 0);
    test_random_frames(125, 0, 84);
    test_random_frames(125, 19, 19);

    s_tvalid <= 1'b0;
    // drain, then give the chain time to show any stray result
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (NUM_HEADS + 8) @(posedge clk);

    $display("sent %0d words over directed, full-store and random frames", words_sent);
    $display("checked %0d body results, %0d of them paired with a head",
             bodies_seen, bodies_paired);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/hbm_pkg.sv
rtl/hbm_cell.sv
rtl/head_to_body_box_matcher.sv
tb/head_to_body_box_matcher_tb.sv
